### src/dsv_pkg.sv
// shared types, constants and helpers for the date string validator
`default_nettype none

package dsv_pkg;

   localparam int CHAR_W      = 8;
   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int YEAR_W      = 14;
   localparam int PAIR_W      = 7;   // value of two decimal digits
   localparam int DIGIT_W     = 4;
   localparam int DM_CNT_W    = 2;
   localparam int YEAR_CNT_W  = 3;

   localparam logic [CHAR_W-1:0] SLASH_CODE = 8'h2F;
   localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] DIGIT_NINE = 8'h39;

   localparam logic [DM_CNT_W-1:0]   DM_MAX_DIGITS   = 2'd2;
   localparam logic [DM_CNT_W-1:0]   DM_SAT_DIGITS   = 2'd3;
   localparam logic [YEAR_CNT_W-1:0] YEAR_SHORT      = 3'd2;
   localparam logic [YEAR_CNT_W-1:0] YEAR_LONG       = 3'd4;
   localparam logic [YEAR_CNT_W-1:0] YEAR_SAT_DIGITS = 3'd5;

   localparam logic [YEAR_W-1:0] CENTURY_BASE = 14'd2000;

   localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
   localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
   localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
   localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;

   typedef enum logic [1:0] {
      FIELD_DAY,
      FIELD_MONTH,
      FIELD_YEAR
   } field_type;

   // days in a month, zero for a month number that does not exist
   function automatic logic [DAY_W-1:0] month_length(input logic [PAIR_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = LEN_LONG;
         7'd4, 7'd6, 7'd9, 7'd11:                    len = LEN_SHORT;
         7'd2:                                       len = leap ? LEN_LEAP : LEN_FEB;
         default:                                    len = '0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

### src/dsv_req_if.sv
// request channel carrying one character of the date string
`default_nettype none

interface dsv_req_if;
   import dsv_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   char_code;
   logic                last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

### src/dsv_rsp_if.sv
// response channel carrying the verdict and the parsed date
`default_nettype none

interface dsv_rsp_if;
   import dsv_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 date_valid;
   logic [DAY_W-1:0]     day;
   logic [MONTH_W-1:0]   month;
   logic [YEAR_W-1:0]    year;

   modport source (output valid, output date_valid, output day, output month,
                   output year, input ready);
   modport sink   (input valid, input date_valid, input day, input month,
                   input year, output ready);
endinterface

`default_nettype wire

### src/date_string_validator.sv
// date string validator: parses d/m/y characters and judges the calendar date
//
//   channel    dir   handshake       payload
//   req_chan   in    valid/ready     char_code[7:0], last_char
//   rsp_chan   out   valid/ready     date_valid, day[4:0], month[3:0], year[13:0]
//
// one request per cycle sustained while the response side keeps up; a character is registered on
// acceptance and parsed from the input register, and the verdict of a last character goes to the
// response register; the parse stage holds a last character while the response register is occupied
// and not being taken; ordinary characters never wait on the response side
// synchronous reset clears parse state and both valid flags
`default_nettype none

module date_string_validator (
   input  wire logic clock,
   input  wire logic reset,
   dsv_req_if.sink   req_chan,
   dsv_rsp_if.source rsp_chan
);
   import dsv_pkg::*;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]   in_char_ff;
   logic                in_last_ff;

   // parse state
   field_type               field_ff, field_in, field_upd;
   logic [DM_CNT_W-1:0]     day_cnt_ff, day_cnt_in, day_cnt_upd;
   logic [DM_CNT_W-1:0]     month_cnt_ff, month_cnt_in, month_cnt_upd;
   logic [YEAR_CNT_W-1:0]   year_cnt_ff, year_cnt_in, year_cnt_upd;
   logic [PAIR_W-1:0]       day_acc_ff, day_acc_in, day_acc_upd;
   logic [PAIR_W-1:0]       month_acc_ff, month_acc_in, month_acc_upd;
   logic [PAIR_W-1:0]       year_hi_ff, year_hi_in, year_hi_upd;   // first two year digits
   logic [PAIR_W-1:0]       year_lo_ff, year_lo_in, year_lo_upd;   // third and fourth
   logic                    error_ff, error_in, error_upd;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_date_valid_ff;
   logic [DAY_W-1:0]     rsp_day_ff;
   logic [MONTH_W-1:0]   rsp_month_ff;
   logic [YEAR_W-1:0]    rsp_year_ff;

   logic                 advance;
   logic                 finish;
   logic                 is_digit;
   logic [DIGIT_W-1:0]   digit;
   logic                 leap;
   logic [DAY_W-1:0]     len;
   logic                 format_ok;
   logic                 date_ok;
   logic [YEAR_W-1:0]    year_value;

   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign finish   = advance && in_last_ff;
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in = (req_chan.valid && req_chan.ready) ? 1'b1 :
                        (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_char_ff <= req_chan.char_code;
         in_last_ff <= req_chan.last_char;
      end
   end

   // character decode and state update
   assign is_digit = (in_char_ff >= DIGIT_ZERO) && (in_char_ff <= DIGIT_NINE);
   assign digit    = DIGIT_W'(in_char_ff - DIGIT_ZERO);

   always_comb begin
      field_upd     = field_ff;
      day_cnt_upd   = day_cnt_ff;
      month_cnt_upd = month_cnt_ff;
      year_cnt_upd  = year_cnt_ff;
      day_acc_upd   = day_acc_ff;
      month_acc_upd = month_acc_ff;
      year_hi_upd   = year_hi_ff;
      year_lo_upd   = year_lo_ff;
      error_upd     = error_ff;
      if (in_char_ff == SLASH_CODE) begin
         case (field_ff)
            FIELD_DAY:   field_upd = FIELD_MONTH;
            FIELD_MONTH: field_upd = FIELD_YEAR;
            default:     error_upd = 1'b1;
         endcase
      end else if (is_digit) begin
         case (field_ff)
            FIELD_DAY: begin
               if (day_cnt_ff < DM_MAX_DIGITS)
                  day_acc_upd = PAIR_W'(day_acc_ff * 7'd10 + PAIR_W'(digit));
               if (day_cnt_ff < DM_SAT_DIGITS)
                  day_cnt_upd = day_cnt_ff + 2'd1;
            end
            FIELD_MONTH: begin
               if (month_cnt_ff < DM_MAX_DIGITS)
                  month_acc_upd = PAIR_W'(month_acc_ff * 7'd10 + PAIR_W'(digit));
               if (month_cnt_ff < DM_SAT_DIGITS)
                  month_cnt_upd = month_cnt_ff + 2'd1;
            end
            default: begin
               if (year_cnt_ff < YEAR_SHORT)
                  year_hi_upd = PAIR_W'(year_hi_ff * 7'd10 + PAIR_W'(digit));
               else if (year_cnt_ff < YEAR_LONG)
                  year_lo_upd = PAIR_W'(year_lo_ff * 7'd10 + PAIR_W'(digit));
               if (year_cnt_ff < YEAR_SAT_DIGITS)
                  year_cnt_upd = year_cnt_ff + 3'd1;
            end
         endcase
      end else begin
         error_upd = 1'b1;
      end
   end

   // verdict on the updated state; mod 4 of a two-digit pair is its low bits
   always_comb begin
      if (year_cnt_upd == YEAR_SHORT)
         leap = (year_hi_upd[1:0] == 2'd0);
      else if (year_lo_upd != '0)
         leap = (year_lo_upd[1:0] == 2'd0);
      else
         leap = (year_hi_upd[1:0] == 2'd0);   // whole century: divisible by 400 test
   end

   assign len = month_length(month_acc_upd, leap);

   assign format_ok = !error_upd && (field_upd == FIELD_YEAR)
                      && (day_cnt_upd == 2'd1 || day_cnt_upd == 2'd2)
                      && (month_cnt_upd == 2'd1 || month_cnt_upd == 2'd2)
                      && (year_cnt_upd == YEAR_SHORT || year_cnt_upd == YEAR_LONG);

   assign date_ok = format_ok && (len != '0) && (day_acc_upd != '0)
                    && (day_acc_upd <= PAIR_W'(len));

   assign year_value = (year_cnt_upd == YEAR_SHORT) ?
                       CENTURY_BASE + YEAR_W'(year_hi_upd) :
                       YEAR_W'(YEAR_W'(year_hi_upd) * 14'd100) + YEAR_W'(year_lo_upd);

   // end of string returns all parse state to its start
   always_comb begin
      if (finish) begin
         field_in     = FIELD_DAY;
         day_cnt_in   = '0;
         month_cnt_in = '0;
         year_cnt_in  = '0;
         day_acc_in   = '0;
         month_acc_in = '0;
         year_hi_in   = '0;
         year_lo_in   = '0;
         error_in     = 1'b0;
      end else if (advance) begin
         field_in     = field_upd;
         day_cnt_in   = day_cnt_upd;
         month_cnt_in = month_cnt_upd;
         year_cnt_in  = year_cnt_upd;
         day_acc_in   = day_acc_upd;
         month_acc_in = month_acc_upd;
         year_hi_in   = year_hi_upd;
         year_lo_in   = year_lo_upd;
         error_in     = error_upd;
      end else begin
         field_in     = field_ff;
         day_cnt_in   = day_cnt_ff;
         month_cnt_in = month_cnt_ff;
         year_cnt_in  = year_cnt_ff;
         day_acc_in   = day_acc_ff;
         month_acc_in = month_acc_ff;
         year_hi_in   = year_hi_ff;
         year_lo_in   = year_lo_ff;
         error_in     = error_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff     <= FIELD_DAY;
         day_cnt_ff   <= '0;
         month_cnt_ff <= '0;
         year_cnt_ff  <= '0;
         day_acc_ff   <= '0;
         month_acc_ff <= '0;
         year_hi_ff   <= '0;
         year_lo_ff   <= '0;
         error_ff     <= 1'b0;
      end else begin
         field_ff     <= field_in;
         day_cnt_ff   <= day_cnt_in;
         month_cnt_ff <= month_cnt_in;
         year_cnt_ff  <= year_cnt_in;
         day_acc_ff   <= day_acc_in;
         month_acc_ff <= month_acc_in;
         year_hi_ff   <= year_hi_in;
         year_lo_ff   <= year_lo_in;
         error_ff     <= error_in;
      end
   end

   // response register
   assign rsp_valid_in = finish ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (finish) begin
         rsp_date_valid_ff <= date_ok;
         rsp_day_ff        <= date_ok ? DAY_W'(day_acc_upd) : '0;
         rsp_month_ff      <= date_ok ? MONTH_W'(month_acc_upd) : '0;
         rsp_year_ff       <= date_ok ? year_value : '0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.date_valid = rsp_date_valid_ff;
   assign rsp_chan.day        = rsp_day_ff;
   assign rsp_chan.month      = rsp_month_ff;
   assign rsp_chan.year       = rsp_year_ff;

   // a rejected date carries zero fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.date_valid |->
         rsp_chan.day == '0 && rsp_chan.month == '0 && rsp_chan.year == '0)
      else $error("rejected date with non-zero fields");

   // an accepted date has a real day and month
   a_accept_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.date_valid |->
         rsp_chan.day != '0 && rsp_chan.month != '0 && rsp_chan.month <= 4'd12)
      else $error("accepted date out of range");

   // a response only appears after a last character was parsed
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(finish))
      else $error("response without a last character");

   // parse state is back at its start after a string ends
   a_restart: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(finish) |->
         field_ff == FIELD_DAY && !error_ff && year_cnt_ff == '0 && day_cnt_ff == '0)
      else $error("parse state not cleared after end of string");

endmodule

`default_nettype wire

### tb/sv/date_string_validator_test.sv
// testbench for the date string validator: directed and random date strings against a predictor
module date_string_validator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dsv_pkg::*;

   typedef logic [CHAR_W-1:0] char_q [$];

   typedef struct {
      field_type              field;
      logic [DM_CNT_W-1:0]    day_cnt;
      logic [DM_CNT_W-1:0]    month_cnt;
      logic [YEAR_CNT_W-1:0]  year_cnt;
      logic [PAIR_W-1:0]      day_val;
      logic [PAIR_W-1:0]      month_val;
      logic [YEAR_W-1:0]      year_val;
      logic                   bad;
   } date_scan;

   typedef struct {
      logic                date_valid;
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
   } date_verdict;

   logic clock = 1'b0;
   logic reset;

   dsv_req_if req_chan ();
   dsv_rsp_if rsp_chan ();

   date_string_validator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   date_scan    scan;
   date_verdict pending_dates [$];
   int          mismatches = 0;
   int          gap_pct    = 0;
   int          stall_pct  = 0;
   int          stall_left = 0;

   always #6 clock = ~clock;

   function automatic void clear_scan();
      scan.field     = FIELD_DAY;
      scan.day_cnt   = '0;
      scan.month_cnt = '0;
      scan.year_cnt  = '0;
      scan.day_val   = '0;
      scan.month_val = '0;
      scan.year_val  = '0;
      scan.bad       = 1'b0;
   endfunction

   function automatic int days_in(input int m, input int y);
      bit leap;
      leap = (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // follows one accepted character; the last one of a string yields a verdict
   function automatic void absorb_char(input logic [CHAR_W-1:0] code, input logic last);
      int          d;
      int          yr;
      int          len;
      bit          ok;
      date_verdict v;
      if (code == SLASH_CODE) begin
         if (scan.field == FIELD_YEAR) scan.bad = 1'b1;
         else if (scan.field == FIELD_DAY) scan.field = FIELD_MONTH;
         else scan.field = FIELD_YEAR;
      end else if (code >= DIGIT_ZERO && code <= DIGIT_NINE) begin
         d = int'(code - DIGIT_ZERO);
         case (scan.field)
            FIELD_DAY: begin
               if (scan.day_cnt < DM_MAX_DIGITS)
                  scan.day_val = PAIR_W'(scan.day_val * 10 + d);
               if (scan.day_cnt < DM_SAT_DIGITS) scan.day_cnt++;
            end
            FIELD_MONTH: begin
               if (scan.month_cnt < DM_MAX_DIGITS)
                  scan.month_val = PAIR_W'(scan.month_val * 10 + d);
               if (scan.month_cnt < DM_SAT_DIGITS) scan.month_cnt++;
            end
            default: begin
               if (scan.year_cnt < YEAR_LONG)
                  scan.year_val = YEAR_W'(scan.year_val * 10 + d);
               if (scan.year_cnt < YEAR_SAT_DIGITS) scan.year_cnt++;
            end
         endcase
      end else begin
         scan.bad = 1'b1;
      end
      if (!last) return;
      ok = !scan.bad && scan.field == FIELD_YEAR
           && (scan.day_cnt == 2'd1 || scan.day_cnt == DM_MAX_DIGITS)
           && (scan.month_cnt == 2'd1 || scan.month_cnt == DM_MAX_DIGITS)
           && (scan.year_cnt == YEAR_SHORT || scan.year_cnt == YEAR_LONG);
      yr = (scan.year_cnt == YEAR_SHORT) ? 2000 + scan.year_val : scan.year_val;
      if (ok) begin
         len = days_in(scan.month_val, yr);
         ok  = len != 0 && scan.day_val >= 1 && scan.day_val <= len;
      end
      v.date_valid = ok;
      v.day        = ok ? scan.day_val[DAY_W-1:0] : '0;
      v.month      = ok ? scan.month_val[MONTH_W-1:0] : '0;
      v.year       = ok ? yr[YEAR_W-1:0] : '0;
      pending_dates.push_back(v);
      clear_scan();
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_verdict();
      date_verdict want;
      if (pending_dates.size() == 0) begin
         report_mismatch("response with no request outstanding");
         return;
      end
      want = pending_dates.pop_front();
      if (rsp_chan.date_valid !== want.date_valid)
         report_mismatch($sformatf("date_valid %b, wanted %b", rsp_chan.date_valid,
                                   want.date_valid));
      if (rsp_chan.day !== want.day)
         report_mismatch($sformatf("day %0d, wanted %0d", rsp_chan.day, want.day));
      if (rsp_chan.month !== want.month)
         report_mismatch($sformatf("month %0d, wanted %0d", rsp_chan.month, want.month));
      if (rsp_chan.year !== want.year)
         report_mismatch($sformatf("year %0d, wanted %0d", rsp_chan.year, want.year));
   endtask

   // response side: check on acceptance, then stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_verdict();
      if (stall_left == 0 && $urandom_range(99) < stall_pct) stall_left = $urandom_range(1, 15);
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // called at a rising edge, returns at the edge where the request is taken
   task automatic send_char(input logic [CHAR_W-1:0] code, input logic last);
      if ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= code;
      req_chan.last_char <= last;
      do @(posedge clock); while (!req_chan.ready);
      absorb_char(code, last);
   endtask

   task automatic send_string(input char_q s);
      for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
   endtask

   function automatic char_q text_chars(input string t);
      char_q s;
      for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
      return s;
   endfunction

   // writes the lowest width decimal digits of value
   function automatic void put_number(ref char_q s, input int value, input int width);
      int p;
      for (int i = width - 1; i >= 0; i--) begin
         p = 1;
         repeat (i) p *= 10;
         s.push_back(CHAR_W'(DIGIT_ZERO + (value / p) % 10));
      end
   endfunction

   function automatic int field_width(input int value);
      int r;
      r = $urandom_range(99);
      if (r < 3) return 0;
      if (r < 8) return 3;
      if (value < 10 && r < 55) return 1;
      return 2;
   endfunction

   function automatic char_q make_date_string();
      char_q s;
      int    dv;
      int    mv;
      int    yv;
      int    yw;
      int    r;
      mv = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(0, 99);
      if ($urandom_range(99) < 25) begin
         // february around its end, day zero now and then
         mv = 2;
         dv = $urandom_range(27, 30);
         if ($urandom_range(99) < 15) dv = 0;
      end else begin
         dv = ($urandom_range(99) < 85) ? $urandom_range(1, 31) : $urandom_range(0, 99);
      end
      put_number(s, dv, field_width(dv));
      s.push_back(SLASH_CODE);
      put_number(s, mv, field_width(mv));
      s.push_back(SLASH_CODE);
      r = $urandom_range(99);
      if (r < 4) begin
         case ($urandom_range(0, 3))
            0: yw = 0;
            1: yw = 1;
            2: yw = 3;
            default: yw = 5;
         endcase
         yv = $urandom_range(0, 9999);
      end else if (r < 50) begin
         yw = 2;
         yv = $urandom_range(0, 99);
      end else begin
         yw = 4;
         yv = $urandom_range(0, 9999);
         if ($urandom_range(99) < 35) begin
            case ($urandom_range(0, 9))
               0: yv = 0;
               1: yv = 1900;
               2: yv = 2000;
               3: yv = 2100;
               4: yv = 2400;
               5: yv = 2023;
               6: yv = 2024;
               7: yv = 1600;
               8: yv = 4;
               default: yv = 9999;
            endcase
         end
      end
      put_number(s, yv, yw);
      return s;
   endfunction

   function automatic void corrupt(ref char_q s);
      int pos;
      pos = $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 3))
         0: s[pos] = CHAR_W'($urandom_range(0, 255));
         1: s.insert(pos, SLASH_CODE);
         2: if (s.size() > 1) s.delete(pos);
         default: s.push_back(SLASH_CODE);
      endcase
   endfunction

   function automatic char_q make_noise();
      char_q s;
      int    r;
      repeat ($urandom_range(1, 12)) begin
         r = $urandom_range(99);
         if (r < 40) s.push_back(CHAR_W'(DIGIT_ZERO + $urandom_range(0, 9)));
         else if (r < 60) s.push_back(SLASH_CODE);
         else s.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      return s;
   endfunction

   // some stretches run with no idling at all
   task automatic shuffle_pacing();
      if ($urandom_range(0, 3) == 0) begin
         gap_pct   = 0;
         stall_pct = 0;
      end else begin
         gap_pct   = $urandom_range(5, 40);
         stall_pct = $urandom_range(2, 15);
      end
   endtask

   task automatic test_calendar_extremes();
      send_string(text_chars("29/2/0000"));
      send_string(text_chars("31/12/99"));
   endtask

   task automatic test_format_errors();
      char_q s;
      s.push_back(8'h00);
      send_string(s);
      s[0] = 8'hFF;
      send_string(s);
      send_string(text_chars("123/"));
      send_string(text_chars("///"));
   endtask

   task automatic test_random_dates(input int budget);
      char_q s;
      int    sent = 0;
      int    n = 0;
      while (sent < budget) begin
         if (n % 25 == 0) shuffle_pacing();
         s = make_date_string();
         send_string(s);
         sent += s.size();
         n++;
      end
   endtask

   task automatic test_broken_strings(input int budget);
      char_q s;
      int    sent = 0;
      int    n = 0;
      while (sent < budget) begin
         if (n % 25 == 0) shuffle_pacing();
         if ($urandom_range(0, 1) == 0) begin
            s = make_date_string();
            corrupt(s);
         end else begin
            s = make_noise();
         end
         send_string(s);
         sent += s.size();
         n++;
      end
   endtask

   task automatic test_steady_stream(input int budget);
      int sent = 0;
      char_q s;
      gap_pct   = 0;
      stall_pct = 0;
      while (sent < budget) begin
         s = make_date_string();
         send_string(s);
         sent += s.size();
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.char_code <= '0;
      req_chan.last_char <= 1'b0;
      clear_scan();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_calendar_extremes();
      test_format_errors();
      test_random_dates(1300);
      test_broken_strings(450);
      test_steady_stream(200);

      req_chan.valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

### files.f
src/dsv_pkg.sv
src/dsv_req_if.sv
src/dsv_rsp_if.sv
src/date_string_validator.sv
tb/sv/date_string_validator_test.sv
